// File: hdl/orbc_pkg.sv
// ----------------------------------------------------------------------------
// Orbit camera package
// Widths, fixed-point constants and small helpers shared by the orbit camera
// datapath, its serial multiplier and its CORDIC unit.
// ----------------------------------------------------------------------------
package orbc_pkg;

  localparam int ANG_W    = 20;  // Q3.16 radians
  localparam int CORDIC_W = 20;  // CORDIC x, y, z working width
  localparam int TRIG_W   = 18;  // Q1.16 sine and cosine, range +-1.0
  localparam int OFF_W    = 18;  // rounded offset from target, Q9.8
  localparam int COORD_W  = 32;  // Q23.8 coordinates
  localparam int DIST_W   = 16;  // Q8.8 distance
  localparam int DELTA_W  = 16;
  localparam int TIME_W   = 16;
  localparam int ATAN_IW  = 5;   // index into the arctangent table

  localparam int MUL_AW = 35;
  localparam int MUL_BW = 18;
  localparam int MUL_PW = MUL_AW + MUL_BW;

  localparam int ANG_PI      = 205887;
  localparam int ANG_TWO_PI  = 411774;
  localparam int ANG_HALF_PI = 102944;
  localparam int PITCH_LIMIT = 99667;
  localparam int CORDIC_GAIN = 39797;
  localparam int TRIG_ONE    = 65536;
  localparam int DIST_RESET  = 1280;

  typedef logic signed [ANG_W-1:0]    angle_t;
  typedef logic signed [TRIG_W-1:0]   trig_t;
  typedef logic signed [COORD_W-1:0]  coord_t;

  // Q16 arctangent of 2^-idx, rounded to nearest
  function automatic logic signed [CORDIC_W-1:0] atan_q16(input logic [ATAN_IW-1:0] idx);
    logic [15:0] v;
    case (idx)
      5'd0:    v = 16'd51472;
      5'd1:    v = 16'd30386;
      5'd2:    v = 16'd16055;
      5'd3:    v = 16'd8150;
      5'd4:    v = 16'd4091;
      5'd5:    v = 16'd2047;
      5'd6:    v = 16'd1024;
      5'd7:    v = 16'd512;
      5'd8:    v = 16'd256;
      5'd9:    v = 16'd128;
      5'd10:   v = 16'd64;
      5'd11:   v = 16'd32;
      5'd12:   v = 16'd16;
      5'd13:   v = 16'd8;
      5'd14:   v = 16'd4;
      5'd15:   v = 16'd2;
      5'd16:   v = 16'd1;
      default: v = 16'd0;
    endcase
    return $signed({{(CORDIC_W-16){1'b0}}, v});
  endfunction

  // floor(delta * dt / 4), clamped to +-pi
  function automatic angle_t angle_step(input logic signed [32:0] p);
    logic signed [32:0] q;
    angle_t r;
    q = p >>> 2;
    if (q > ANG_PI) begin
      r = ANG_W'(ANG_PI);
    end else if (q < -ANG_PI) begin
      r = ANG_W'(-ANG_PI);
    end else begin
      r = q[ANG_W-1:0];
    end
    return r;
  endfunction

  // clamp a 33-bit sum to the signed 32-bit range
  function automatic coord_t sat_coord(input logic signed [COORD_W:0] v);
    coord_t r;
    if (v[COORD_W] != v[COORD_W-1]) begin
      r = v[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
    end else begin
      r = v[COORD_W-1:0];
    end
    return r;
  endfunction

endpackage

// File: hdl/orbc_smul.sv
// ----------------------------------------------------------------------------
// Orbit camera serial multiplier
// Signed shift-add multiplier: one bit of the multiplier per cycle, the sign
// bit last and subtracted; done pulses once the product is complete.
// ----------------------------------------------------------------------------
module orbc_smul (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic signed [orbc_pkg::MUL_AW-1:0]   a_i,
  input  logic signed [orbc_pkg::MUL_BW-1:0]   b_i,
  output logic                                 done_o,
  output logic        [orbc_pkg::MUL_PW-1:0]   p_o
);
  import orbc_pkg::*;

  localparam int CNT_W = $clog2(MUL_BW);

  logic                run_q, done_q;
  logic [CNT_W-1:0]    cnt_q;
  logic [MUL_PW-1:0]   a_q, acc_q, acc_d, addend;
  logic [MUL_BW-1:0]   b_q;
  logic                last;

  assign last   = (cnt_q == CNT_W'(MUL_BW-1));
  assign addend = b_q[0] ? a_q : '0;
  assign acc_d  = last ? acc_q - addend : acc_q + addend;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (last) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= MUL_PW'(a_i);
      b_q   <= b_i;
      acc_q <= '0;
    end else if (run_q) begin
      acc_q <= acc_d;
      a_q   <= a_q << 1;
      b_q   <= b_q >> 1;
    end
  end

  assign done_o = done_q;
  assign p_o    = acc_q;

endmodule

// File: hdl/orbc_cordic.sv
// ----------------------------------------------------------------------------
// Orbit camera CORDIC
// Rotation-mode CORDIC, one micro-rotation per cycle, with a quadrant fold
// on entry and negation plus a +-1.0 clamp on the way out.
// ----------------------------------------------------------------------------
module orbc_cordic #(
  parameter int STEPS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  orbc_pkg::angle_t      angle_i,
  output logic                  done_o,
  output orbc_pkg::trig_t       sin_o,
  output orbc_pkg::trig_t       cos_o
);
  import orbc_pkg::*;

  logic                         run_q, done_q;
  logic [ATAN_IW-1:0]           i_q;
  logic signed [CORDIC_W-1:0]   x_q, y_q, z_q, x_d, y_d, z_d, xs, ys, at, z0;
  logic signed [CORDIC_W-1:0]   xf, yf;
  logic                         neg_q, neg0, last;

  assign last = (i_q == ATAN_IW'(STEPS-1));

  // fold angles beyond a quarter turn back by pi
  always_comb begin
    z0   = CORDIC_W'(angle_i);
    neg0 = 1'b0;
    if (angle_i > ANG_HALF_PI) begin
      z0   = CORDIC_W'(angle_i) - CORDIC_W'(ANG_PI);
      neg0 = 1'b1;
    end else if (angle_i < -ANG_HALF_PI) begin
      z0   = CORDIC_W'(angle_i) + CORDIC_W'(ANG_PI);
      neg0 = 1'b1;
    end
  end

  always_comb begin
    xs = x_q >>> i_q;
    ys = y_q >>> i_q;
    at = atan_q16(i_q);
    if (!z_q[CORDIC_W-1]) begin
      x_d = x_q - ys;
      y_d = y_q + xs;
      z_d = z_q - at;
    end else begin
      x_d = x_q + ys;
      y_d = y_q - xs;
      z_d = z_q + at;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      i_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        i_q   <= '0;
      end else if (run_q) begin
        i_q <= i_q + 1'b1;
        if (last) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q   <= CORDIC_W'(CORDIC_GAIN);
      y_q   <= '0;
      z_q   <= z0;
      neg_q <= neg0;
    end else if (run_q) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  always_comb begin
    xf = neg_q ? -x_q : x_q;
    yf = neg_q ? -y_q : y_q;
    if (xf > TRIG_ONE) begin
      cos_o = TRIG_W'(TRIG_ONE);
    end else if (xf < -TRIG_ONE) begin
      cos_o = TRIG_W'(-TRIG_ONE);
    end else begin
      cos_o = xf[TRIG_W-1:0];
    end
    if (yf > TRIG_ONE) begin
      sin_o = TRIG_W'(TRIG_ONE);
    end else if (yf < -TRIG_ONE) begin
      sin_o = TRIG_W'(-TRIG_ONE);
    end else begin
      sin_o = yf[TRIG_W-1:0];
    end
  end

  assign done_o = done_q;

endmodule

// File: hdl/orbit_camera_update.sv
// ----------------------------------------------------------------------------
// Orbit camera update
// Turns pointer movement into yaw and pitch, and places a third-person
// camera on a sphere round the target.
// ----------------------------------------------------------------------------
// One word in gives one word out. Yaw and pitch live inside the block and
// are cleared by reset; orbit distance is written through cfg_we_i while the
// block is idle, which the user must keep to as the block itself does not
// enforce it, and resets to 5.0. A word is taken only in the idle state, so
// the next word waits until the last one is through. The six products (two
// angle steps, d*cos(pitch), its products with cos and sin of yaw,
// d*sin(pitch)) share one bit-serial multiplier; the sine and cosine of both
// angles come from one iterative CORDIC; then come the coordinate sums and
// the output load. A finished result sits in the output register, so the
// next word is taken while it waits; a result side that stalls until that
// word is done holds it in its last state until the register frees.
// ----------------------------------------------------------------------------
module orbit_camera_update #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [15:0]   cfg_wdata_i,    // orbit_distance
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // pointer_dx, pointer_dy, frame_time, target_x, target_y, target_z
  input  logic [143:0]  s_axis_tdata,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // cam_x, cam_y, cam_z, look_x, look_y, look_z
  output logic [191:0]  m_axis_tdata
);
  import orbc_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MUL_H = 4'd1;
  localparam logic [3:0] S_MUL_V = 4'd2;
  localparam logic [3:0] S_COR_Y = 4'd3;
  localparam logic [3:0] S_COR_P = 4'd4;
  localparam logic [3:0] S_MUL_R = 4'd5;
  localparam logic [3:0] S_MUL_X = 4'd6;
  localparam logic [3:0] S_MUL_Z = 4'd7;
  localparam logic [3:0] S_MUL_Y = 4'd8;
  localparam logic [3:0] S_SUM   = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;

  localparam logic [MUL_PW-1:0] HALF_Q32 = {{(MUL_PW-32){1'b0}}, 1'b1, 31'b0};
  localparam logic [MUL_PW-1:0] HALF_Q16 = {{(MUL_PW-16){1'b0}}, 1'b1, 15'b0};

  logic [3:0]                 state_q;
  logic [DIST_W-1:0]          dist_q;
  angle_t                     yaw_q, pitch_q, yaw_d, pitch_d, step;
  logic signed [ANG_W:0]      yaw_sum, pitch_sum;
  logic                       out_valid_q, in_fire, load_out;
  logic                       mul_go_q, mul_done, cor_go_q, cor_done;
  logic signed [MUL_AW-1:0]   mul_a_q;
  logic signed [MUL_BW-1:0]   mul_b_q;
  logic [MUL_PW-1:0]          mul_p, rnd32, rnd16;
  angle_t                     cor_ang_q;
  trig_t                      cor_sin, cor_cos, sy_q, cy_q, sp_q;
  logic signed [DELTA_W-1:0]  dv_q;
  logic [TIME_W-1:0]          dt_q;
  coord_t                     tx_q, ty_q, tz_q, camx_q, camy_q, camz_q;
  coord_t                     lookx, looky, lookz;
  logic signed [33:0]         rxz_q;
  logic signed [OFF_W-1:0]    ox_q, oy_q, oz_q;
  logic [191:0]               out_data_q;

  orbc_smul u_smul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_go_q),
    .a_i     (mul_a_q),
    .b_i     (mul_b_q),
    .done_o  (mul_done),
    .p_o     (mul_p)
  );

  orbc_cordic #(
    .STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cor_go_q),
    .angle_i (cor_ang_q),
    .done_o  (cor_done),
    .sin_o   (cor_sin),
    .cos_o   (cor_cos)
  );

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign load_out      = (state_q == S_OUT) && (!out_valid_q || m_axis_tready);

  assign rnd32 = mul_p + HALF_Q32;
  assign rnd16 = mul_p + HALF_Q16;

  // wrap yaw into [-pi, pi), clamp pitch short of straight up or down
  always_comb begin
    step      = angle_step(mul_p[32:0]);
    yaw_sum   = (ANG_W+1)'(yaw_q) + (ANG_W+1)'(step);
    pitch_sum = (ANG_W+1)'(pitch_q) - (ANG_W+1)'(step);
    if (yaw_sum >= ANG_PI) begin
      yaw_d = ANG_W'(yaw_sum - (ANG_W+1)'(ANG_TWO_PI));
    end else if (yaw_sum < -ANG_PI) begin
      yaw_d = ANG_W'(yaw_sum + (ANG_W+1)'(ANG_TWO_PI));
    end else begin
      yaw_d = yaw_sum[ANG_W-1:0];
    end
    if (pitch_sum > PITCH_LIMIT) begin
      pitch_d = ANG_W'(PITCH_LIMIT);
    end else if (pitch_sum < -PITCH_LIMIT) begin
      pitch_d = ANG_W'(-PITCH_LIMIT);
    end else begin
      pitch_d = pitch_sum[ANG_W-1:0];
    end
  end

  assign lookx = sat_coord((COORD_W+1)'(tx_q) - (COORD_W+1)'(camx_q));
  assign looky = sat_coord((COORD_W+1)'(ty_q) - (COORD_W+1)'(camy_q));
  assign lookz = sat_coord((COORD_W+1)'(tz_q) - (COORD_W+1)'(camz_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      dist_q      <= DIST_W'(DIST_RESET);
      yaw_q       <= '0;
      pitch_q     <= '0;
      out_valid_q <= 1'b0;
      mul_go_q    <= 1'b0;
      cor_go_q    <= 1'b0;
    end else begin
      mul_go_q <= 1'b0;
      cor_go_q <= 1'b0;
      if (cfg_we_i) begin
        dist_q <= cfg_wdata_i;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            mul_go_q <= 1'b1;
            state_q  <= S_MUL_H;
          end
        end
        S_MUL_H: begin
          if (mul_done) begin
            yaw_q    <= yaw_d;
            mul_go_q <= 1'b1;
            state_q  <= S_MUL_V;
          end
        end
        S_MUL_V: begin
          if (mul_done) begin
            pitch_q  <= pitch_d;
            cor_go_q <= 1'b1;
            state_q  <= S_COR_Y;
          end
        end
        S_COR_Y: begin
          if (cor_done) begin
            cor_go_q <= 1'b1;
            state_q  <= S_COR_P;
          end
        end
        S_COR_P: begin
          if (cor_done) begin
            mul_go_q <= 1'b1;
            state_q  <= S_MUL_R;
          end
        end
        S_MUL_R: begin
          if (mul_done) begin
            mul_go_q <= 1'b1;
            state_q  <= S_MUL_X;
          end
        end
        S_MUL_X: begin
          if (mul_done) begin
            mul_go_q <= 1'b1;
            state_q  <= S_MUL_Z;
          end
        end
        S_MUL_Z: begin
          if (mul_done) begin
            mul_go_q <= 1'b1;
            state_q  <= S_MUL_Y;
          end
        end
        S_MUL_Y: begin
          if (mul_done) begin
            state_q <= S_SUM;
          end
        end
        S_SUM: begin
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (load_out) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          dv_q    <= $signed(s_axis_tdata[31:16]);
          dt_q    <= s_axis_tdata[47:32];
          tx_q    <= $signed(s_axis_tdata[79:48]);
          ty_q    <= $signed(s_axis_tdata[111:80]);
          tz_q    <= $signed(s_axis_tdata[143:112]);
          mul_a_q <= $signed({{(MUL_AW-TIME_W){1'b0}}, s_axis_tdata[47:32]});
          mul_b_q <= MUL_BW'($signed(s_axis_tdata[15:0]));
        end
      end
      S_MUL_H: begin
        if (mul_done) begin
          mul_a_q <= $signed({{(MUL_AW-TIME_W){1'b0}}, dt_q});
          mul_b_q <= MUL_BW'(dv_q);
        end
      end
      S_MUL_V: begin
        if (mul_done) begin
          cor_ang_q <= yaw_q;
        end
      end
      S_COR_Y: begin
        if (cor_done) begin
          sy_q      <= cor_sin;
          cy_q      <= cor_cos;
          cor_ang_q <= pitch_q;
        end
      end
      S_COR_P: begin
        if (cor_done) begin
          sp_q    <= cor_sin;
          mul_a_q <= $signed({{(MUL_AW-DIST_W){1'b0}}, dist_q});
          mul_b_q <= MUL_BW'(cor_cos);
        end
      end
      S_MUL_R: begin
        if (mul_done) begin
          rxz_q   <= $signed(mul_p[33:0]);
          mul_a_q <= MUL_AW'($signed(mul_p[33:0]));
          mul_b_q <= MUL_BW'(cy_q);
        end
      end
      S_MUL_X: begin
        if (mul_done) begin
          ox_q    <= $signed(rnd32[32+OFF_W-1:32]);
          mul_a_q <= MUL_AW'(rxz_q);
          mul_b_q <= MUL_BW'(sy_q);
        end
      end
      S_MUL_Z: begin
        if (mul_done) begin
          oz_q    <= $signed(rnd32[32+OFF_W-1:32]);
          mul_a_q <= $signed({{(MUL_AW-DIST_W){1'b0}}, dist_q});
          mul_b_q <= MUL_BW'(sp_q);
        end
      end
      S_MUL_Y: begin
        if (mul_done) begin
          oy_q <= $signed(rnd16[16+OFF_W-1:16]);
        end
      end
      S_SUM: begin
        camx_q <= sat_coord((COORD_W+1)'(tx_q) + (COORD_W+1)'(ox_q));
        camy_q <= sat_coord((COORD_W+1)'(ty_q) + (COORD_W+1)'(oy_q));
        camz_q <= sat_coord((COORD_W+1)'(tz_q) + (COORD_W+1)'(oz_q));
      end
      S_OUT: begin
        if (load_out) begin
          out_data_q <= {lookz, looky, lookx, camz_q, camy_q, camx_q};
        end
      end
      default: begin
      end
    endcase
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule
